// File: rtl/rab_pkg.sv
// ============================================================================
// rab_pkg - shared types and constants for the rectangle alpha blend engine
// Item layouts, configuration register map, blend mode codes and the
// divide-by-255 helper used by the blend datapath.
// ============================================================================
package rab_pkg;

    localparam int MAX_SCREEN_WIDTH_DEF = 2048;
    localparam int MAX_SCREEN_HEIGHT    = 2048;

    localparam int CH_W       = 8;
    localparam int ADDR_W     = 22;
    localparam int SIZE_W     = 12;
    localparam int POS_W      = 11;
    localparam int CNT_W      = 11;
    localparam int ABS_W      = 12;
    localparam int RECT_MAX   = 2048;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [ADDR_W-1:0] ADDR_MASK  = {ADDR_W{1'b1}};
    localparam logic [CH_W-1:0]   ALPHA_FULL = 8'hff;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RECT_WIDTH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RECT_HEIGHT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_X       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_Y       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_MODE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_COLOR   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_ALPHA   = 3'd7;

    typedef enum logic [1:0] {
        MODE_ALPHA = 2'd0,
        MODE_FILL  = 2'd1,
        MODE_COPY  = 2'd2
    } blend_mode_t;

    typedef struct packed {
        logic [SIZE_W-1:0] screen_width;
        logic [SIZE_W-1:0] rect_width;
        logic [SIZE_W-1:0] rect_height;
        logic [POS_W-1:0]  dest_x;
        logic [POS_W-1:0]  dest_y;
        logic [1:0]        blend_mode;
        logic [23:0]       fill_color;
        logic [CH_W-1:0]   fill_alpha;
    } cfg_t;

    typedef struct packed {
        logic [CH_W-1:0] src_red;
        logic [CH_W-1:0] src_green;
        logic [CH_W-1:0] src_blue;
        logic [CH_W-1:0] src_fourth;
        logic [CH_W-1:0] src_alpha;
        logic [CH_W-1:0] dst_red;
        logic [CH_W-1:0] dst_green;
        logic [CH_W-1:0] dst_blue;
    } pix_in_t;

    typedef struct packed {
        logic [ADDR_W-1:0] pixel_address;
        logic [CH_W-1:0]   out_red;
        logic [CH_W-1:0]   out_green;
        logic [CH_W-1:0]   out_blue;
        logic [CH_W-1:0]   out_fourth;
        logic              write_fourth;
        logic              out_of_frame;
        logic              last_of_rect;
    } pix_out_t;

    // Raster position of the pixel at the head of the input channel
    typedef struct packed {
        logic [ABS_W-1:0] abs_col;
        logic [ABS_W-1:0] abs_row;
        logic             last;
    } scan_t;

    // Exact floor(x/255) for x up to 255*255
    function automatic logic [CH_W-1:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        return t[15:8];
    endfunction

endpackage

// File: rtl/rab_ifs.sv
// ============================================================================
// rab_ifs - channel interfaces of the rectangle alpha blend engine
// Valid/ready stream channel with a typed payload, and the register
// write channel.
// ============================================================================
interface rab_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rab_cfg_if;
    import rab_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/rab_cfg_regs.sv
// ============================================================================
// rab_cfg_regs - configuration register file
// Holds the eight blit registers; writes are registered and always accepted.
// ============================================================================
module rab_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_valid,
    output logic                           wr_ready,
    input  logic [rab_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [rab_pkg::CFG_DATA_W-1:0] wr_data,
    output rab_pkg::cfg_t                  cfg
);
    import rab_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign wr_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_valid)
        begin
            unique case (wr_index)
                CFG_SCREEN_WIDTH: cfg_next.screen_width = wr_data[SIZE_W-1:0];
                CFG_RECT_WIDTH:   cfg_next.rect_width   = wr_data[SIZE_W-1:0];
                CFG_RECT_HEIGHT:  cfg_next.rect_height  = wr_data[SIZE_W-1:0];
                CFG_DEST_X:       cfg_next.dest_x       = wr_data[POS_W-1:0];
                CFG_DEST_Y:       cfg_next.dest_y       = wr_data[POS_W-1:0];
                CFG_BLEND_MODE:   cfg_next.blend_mode   = wr_data[1:0];
                CFG_FILL_COLOR:   cfg_next.fill_color   = wr_data[23:0];
                CFG_FILL_ALPHA:   cfg_next.fill_alpha   = wr_data[CH_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.screen_width <= 12'd1024;
            cfg_reg.rect_width   <= 12'd1;
            cfg_reg.rect_height  <= 12'd1;
            cfg_reg.dest_x       <= '0;
            cfg_reg.dest_y       <= '0;
            cfg_reg.blend_mode   <= MODE_ALPHA;
            cfg_reg.fill_color   <= '0;
            cfg_reg.fill_alpha   <= ALPHA_FULL;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: rtl/rab_raster_cnt.sv
// ============================================================================
// rab_raster_cnt - raster column/row counters
// Track the position inside the rectangle and flag its final pixel.
// ============================================================================
module rab_raster_cnt (
    input  logic           clk,
    input  logic           rst_n,
    input  rab_pkg::cfg_t  cfg,
    input  logic           advance,
    output rab_pkg::scan_t scan
);
    import rab_pkg::*;

    logic [CNT_W-1:0]  col_reg;
    logic [CNT_W-1:0]  col_next;
    logic [CNT_W-1:0]  row_reg;
    logic [CNT_W-1:0]  row_next;
    logic [SIZE_W-1:0] rw;
    logic [SIZE_W-1:0] rh;
    logic [SIZE_W-1:0] col_inc;
    logic [SIZE_W-1:0] row_inc;
    logic              last_col;
    logic              last_row;

    // Saturate the size registers into 1..RECT_MAX
    always_comb
    begin
        if (cfg.rect_width == '0)
            rw = SIZE_W'(1);
        else if (32'(cfg.rect_width) > 32'(RECT_MAX))
            rw = SIZE_W'(RECT_MAX);
        else
            rw = cfg.rect_width;

        if (cfg.rect_height == '0)
            rh = SIZE_W'(1);
        else if (32'(cfg.rect_height) > 32'(RECT_MAX))
            rh = SIZE_W'(RECT_MAX);
        else
            rh = cfg.rect_height;
    end

    assign col_inc  = {1'b0, col_reg} + SIZE_W'(1);
    assign row_inc  = {1'b0, row_reg} + SIZE_W'(1);
    assign last_col = col_inc >= rw;
    assign last_row = row_inc >= rh;

    assign scan.abs_col = {1'b0, cfg.dest_x} + {1'b0, col_reg};
    assign scan.abs_row = {1'b0, cfg.dest_y} + {1'b0, row_reg};
    assign scan.last    = last_col && last_row;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (advance)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_inc[CNT_W-1:0];
            end
            else
            begin
                col_next = col_inc[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// File: rtl/rab_datapath.sv
// ============================================================================
// rab_datapath - three-stage blend and address pipeline
// Operand select, multiply, then divide-by-255 and address add.
// ============================================================================
module rab_datapath #(
    parameter int MAX_SCREEN_WIDTH = rab_pkg::MAX_SCREEN_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  rab_pkg::cfg_t     cfg,
    input  rab_pkg::scan_t    scan,
    input  logic              in_valid,
    output logic              in_ready,
    input  rab_pkg::pix_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output rab_pkg::pix_out_t out_data
);
    import rab_pkg::*;

    localparam int SW_W   = $clog2(MAX_SCREEN_WIDTH + 1);
    localparam int PROD_W = ABS_W + SW_W;
    localparam int FULL_W = PROD_W + 1;

    // Stage enables
    logic en_s1;
    logic en_s2;
    logic en_out;

    // Operand select
    logic [CH_W-1:0]            sel_alpha;
    logic [2:0][CH_W-1:0]       sel_src;
    logic [2:0][CH_W-1:0]       sel_dst;
    logic [CH_W-1:0]            sel_fourth;
    logic                       sel_wr4;

    // Stage 1
    logic                       s1_valid_reg;
    logic [CH_W-1:0]            s1_alpha_reg;
    logic [2:0][CH_W-1:0]       s1_src_reg;
    logic [2:0][CH_W-1:0]       s1_dst_reg;
    logic [CH_W-1:0]            s1_fourth_reg;
    logic                       s1_wr4_reg;
    logic [ABS_W-1:0]           s1_col_reg;
    logic [ABS_W-1:0]           s1_row_reg;
    logic                       s1_last_reg;

    // Stage 2
    logic [SW_W-1:0]            sw;
    logic [CH_W-1:0]            s1_alpha_inv;
    logic [2:0][15:0]           sum_next;
    logic                       s2_valid_reg;
    logic [2:0][15:0]           s2_sum_reg;
    logic [PROD_W-1:0]          s2_base_reg;
    logic [ABS_W-1:0]           s2_col_reg;
    logic                       s2_rowhi_reg;
    logic [CH_W-1:0]            s2_fourth_reg;
    logic                       s2_wr4_reg;
    logic                       s2_last_reg;

    // Output stage
    logic [FULL_W-1:0]          full;
    pix_out_t                   out_next;
    logic                       out_valid_reg;
    pix_out_t                   out_reg;

    assign en_out   = !out_valid_reg || out_ready;
    assign en_s2    = !s2_valid_reg || en_out;
    assign en_s1    = !s1_valid_reg || en_s2;
    assign in_ready = en_s1;

    // Copy mode runs through the blend at full opacity, which returns the
    // source unchanged; the reserved mode code copies as well.
    always_comb
    begin
        sel_dst    = {in_data.dst_red, in_data.dst_green, in_data.dst_blue};
        sel_src    = {in_data.src_red, in_data.src_green, in_data.src_blue};
        sel_alpha  = ALPHA_FULL;
        sel_fourth = '0;
        sel_wr4    = 1'b0;
        case (cfg.blend_mode)
            MODE_ALPHA:
            begin
                sel_alpha = in_data.src_alpha;
            end
            MODE_FILL:
            begin
                sel_alpha = cfg.fill_alpha;
                sel_src   = {cfg.fill_color[23:16], cfg.fill_color[15:8],
                             cfg.fill_color[7:0]};
            end
            default:
            begin
                sel_fourth = in_data.src_fourth;
                sel_wr4    = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en_s1)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en_s1 && in_valid)
        begin
            s1_alpha_reg  <= sel_alpha;
            s1_src_reg    <= sel_src;
            s1_dst_reg    <= sel_dst;
            s1_fourth_reg <= sel_fourth;
            s1_wr4_reg    <= sel_wr4;
            s1_col_reg    <= scan.abs_col;
            s1_row_reg    <= scan.abs_row;
            s1_last_reg   <= scan.last;
        end
    end

    // Saturate the row stride into 1..MAX_SCREEN_WIDTH
    always_comb
    begin
        if (cfg.screen_width == '0)
            sw = SW_W'(1);
        else if (32'(cfg.screen_width) > 32'(MAX_SCREEN_WIDTH))
            sw = SW_W'(MAX_SCREEN_WIDTH);
        else
            sw = SW_W'(cfg.screen_width);
    end

    assign s1_alpha_inv = ALPHA_FULL - s1_alpha_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sum_next[i] = 16'(s1_alpha_reg) * 16'(s1_src_reg[i])
                        + 16'(s1_alpha_inv) * 16'(s1_dst_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (en_s2)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en_s2 && s1_valid_reg)
        begin
            s2_sum_reg    <= sum_next;
            s2_base_reg   <= PROD_W'(s1_row_reg) * PROD_W'(sw);
            s2_col_reg    <= s1_col_reg;
            s2_rowhi_reg  <= 32'(s1_row_reg) >= 32'(MAX_SCREEN_HEIGHT);
            s2_fourth_reg <= s1_fourth_reg;
            s2_wr4_reg    <= s1_wr4_reg;
            s2_last_reg   <= s1_last_reg;
        end
    end

    assign full = FULL_W'(s2_base_reg) + FULL_W'(s2_col_reg);

    always_comb
    begin
        out_next.pixel_address = ADDR_W'(full);
        out_next.out_red       = div255(s2_sum_reg[2]);
        out_next.out_green     = div255(s2_sum_reg[1]);
        out_next.out_blue      = div255(s2_sum_reg[0]);
        out_next.out_fourth    = s2_fourth_reg;
        out_next.write_fourth  = s2_wr4_reg;
        out_next.out_of_frame  = (32'(s2_col_reg) >= 32'(sw)) || s2_rowhi_reg
                               || (32'(full) > 32'(ADDR_MASK));
        out_next.last_of_rect  = s2_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en_out)
            out_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en_out && s2_valid_reg)
            out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// File: rtl/rect_alpha_blend_engine.sv
// ============================================================================
// rect_alpha_blend_engine - rectangle alpha blend / fill / copy compositor
// Takes one pixel of a rectangle per transaction in raster order and returns
// its linear frame address together with the new channel values.
// ============================================================================
// Pipeline: an accepted input transaction passes the operand register, the
//   multiply register and the result register to reach the output channel.
// Throughput: one pixel per cycle; the three-stage pipeline stalls only when
//   the output channel holds a result that has not been taken.
// Reset: rst_n clears the pipeline valids and the raster counters and loads
//   the register defaults (stride 1024, 1x1 rectangle, fill alpha 255).
// ============================================================================
module rect_alpha_blend_engine #(
    parameter int MAX_SCREEN_WIDTH = rab_pkg::MAX_SCREEN_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    rab_stream_if.sink    pix_in,
    rab_stream_if.source  pix_out,
    rab_cfg_if.sink       cfg
);
    import rab_pkg::*;

    cfg_t  cfg_q;
    scan_t scan;
    logic  in_ready;
    logic  in_accept;

    // Register file: writes are always taken; users must send them only between
    // rectangles or while the pipeline is drained; the block does not enforce it.
    rab_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (cfg.valid),
        .wr_ready (cfg.ready),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg      (cfg_q)
    );

    // Advance the raster position on every accepted pixel transaction.
    assign in_accept    = pix_in.valid && in_ready;
    assign pix_in.ready = in_ready;

    rab_raster_cnt u_raster_cnt (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_q),
        .advance (in_accept),
        .scan    (scan)
    );

    // Blend and address pipeline; ready back-propagates from the output
    // register so a stalled result holds everything behind it.
    rab_datapath #(
        .MAX_SCREEN_WIDTH (MAX_SCREEN_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_q),
        .scan      (scan),
        .in_valid  (pix_in.valid),
        .in_ready  (in_ready),
        .in_data   (pix_in.data),
        .out_valid (pix_out.valid),
        .out_ready (pix_out.ready),
        .out_data  (pix_out.data)
    );

endmodule

// File: rtl/rab_checker.sv
// ============================================================================
// rab_checker - port-level assertions for the rectangle alpha blend engine
// Watches the channels of the top level; attached by bind.
// ============================================================================
module rab_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [rab_pkg::CH_W-1:0] out_fourth,
    input logic                 write_fourth
);
    import rab_pkg::*;

    // Hold a stalled result until it is taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output transaction dropped while stalled");

    // A free output side must leave the input side open (no pipeline bubble)
    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled although output is ready");

    // Byte 3 is only carried in copy mode
    a_fourth_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !write_fourth |-> out_fourth == '0)
        else $error("byte 3 set outside copy mode");

endmodule

bind rect_alpha_blend_engine rab_checker u_rab_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (pix_in.ready),
    .out_valid    (pix_out.valid),
    .out_ready    (pix_out.ready),
    .out_fourth   (pix_out.data.out_fourth),
    .write_fourth (pix_out.data.write_fourth)
);

// File: tb/sv/rect_alpha_blend_engine_checker.sv
// ============================================================================
// rect_alpha_blend_engine_checker - result checker for the blend engine
// Watches the register write, pixel input and pixel output channels. It keeps
// its own copy of the registers and the raster counters and works out the
// expected result of every accepted pixel. Each result taken from the block
// is compared field by field with the oldest expected one.
// ============================================================================
module rect_alpha_blend_engine_checker #(
    parameter int MAX_SCREEN_WIDTH = rab_pkg::MAX_SCREEN_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [rab_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rab_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  rab_pkg::pix_in_t               in_data,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  rab_pkg::pix_out_t              out_data,
    output int                             mismatches,
    output int                             outstanding
);
    import rab_pkg::*;

    cfg_t             regs;
    logic [CNT_W-1:0] col_cnt;
    logic [CNT_W-1:0] row_cnt;
    pix_out_t         expected_pixels[$];

    function automatic int unsigned clamp_extent(input int unsigned v, input int unsigned hi);
        if (v == 0)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // floor((a*s + (255-a)*d) / 255)
    function automatic logic [CH_W-1:0] mix_channel(input logic [CH_W-1:0] a,
                                                    input logic [CH_W-1:0] s,
                                                    input logic [CH_W-1:0] d);
        int unsigned acc;
        acc = int'(a) * int'(s) + (int'(ALPHA_FULL) - int'(a)) * int'(d);
        return CH_W'(acc / int'(ALPHA_FULL));
    endfunction

    function automatic pix_out_t predict_pixel(input pix_in_t p);
        pix_out_t          r;
        longint unsigned   stride;
        longint unsigned   abs_col;
        longint unsigned   abs_row;
        longint unsigned   full;
        int unsigned       rw;
        int unsigned       rh;
        r       = '0;
        stride  = clamp_extent(regs.screen_width, MAX_SCREEN_WIDTH);
        rw      = clamp_extent(regs.rect_width, RECT_MAX);
        rh      = clamp_extent(regs.rect_height, RECT_MAX);
        abs_col = longint'(regs.dest_x) + longint'(col_cnt);
        abs_row = longint'(regs.dest_y) + longint'(row_cnt);
        full    = abs_row * stride + abs_col;

        case (regs.blend_mode)
            MODE_ALPHA:
            begin
                r.out_red   = mix_channel(p.src_alpha, p.src_red, p.dst_red);
                r.out_green = mix_channel(p.src_alpha, p.src_green, p.dst_green);
                r.out_blue  = mix_channel(p.src_alpha, p.src_blue, p.dst_blue);
            end
            MODE_FILL:
            begin
                r.out_red   = mix_channel(regs.fill_alpha, regs.fill_color[23:16], p.dst_red);
                r.out_green = mix_channel(regs.fill_alpha, regs.fill_color[15:8], p.dst_green);
                r.out_blue  = mix_channel(regs.fill_alpha, regs.fill_color[7:0], p.dst_blue);
            end
            default:
            begin
                // copy, and the unused code behaves the same
                r.out_red      = p.src_red;
                r.out_green    = p.src_green;
                r.out_blue     = p.src_blue;
                r.out_fourth   = p.src_fourth;
                r.write_fourth = 1'b1;
            end
        endcase

        r.pixel_address = ADDR_W'(full);
        r.out_of_frame  = (abs_col >= stride) || (abs_row >= MAX_SCREEN_HEIGHT) ||
                          (full > longint'(ADDR_MASK));
        r.last_of_rect  = (int'(col_cnt) + 1 >= rw) && (int'(row_cnt) + 1 >= rh);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pix_out_t   exp_pix;
        int unsigned rw;
        int unsigned rh;
        if (!rst_n)
        begin
            regs.screen_width = SIZE_W'(1024);
            regs.rect_width   = SIZE_W'(1);
            regs.rect_height  = SIZE_W'(1);
            regs.dest_x       = '0;
            regs.dest_y       = '0;
            regs.blend_mode   = MODE_ALPHA;
            regs.fill_color   = '0;
            regs.fill_alpha   = ALPHA_FULL;
            col_cnt           = '0;
            row_cnt           = '0;
            expected_pixels.delete();
            mismatches        = 0;
            outstanding       = 0;
        end
        else
        begin
            // compare a taken result with the oldest expectation
            if (out_valid && out_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] unexpected result: addr=%06h", $realtime,
                                 out_data.pixel_address);
                end
                else
                begin
                    exp_pix = expected_pixels.pop_front();
                    if (out_data.pixel_address !== exp_pix.pixel_address ||
                        out_data.out_red       !== exp_pix.out_red       ||
                        out_data.out_green     !== exp_pix.out_green     ||
                        out_data.out_blue      !== exp_pix.out_blue      ||
                        out_data.out_fourth    !== exp_pix.out_fourth    ||
                        out_data.write_fourth  !== exp_pix.write_fourth  ||
                        out_data.out_of_frame  !== exp_pix.out_of_frame  ||
                        out_data.last_of_rect  !== exp_pix.last_of_rect)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("[%0t] pixel mismatch", $realtime);
                            $display("  expected addr=%06h rgb=%02h %02h %02h",
                                     exp_pix.pixel_address, exp_pix.out_red,
                                     exp_pix.out_green, exp_pix.out_blue,
                                     " b3=%02h w4=%b oof=%b last=%b",
                                     exp_pix.out_fourth, exp_pix.write_fourth,
                                     exp_pix.out_of_frame, exp_pix.last_of_rect);
                            $display("  actual   addr=%06h rgb=%02h %02h %02h",
                                     out_data.pixel_address, out_data.out_red,
                                     out_data.out_green, out_data.out_blue,
                                     " b3=%02h w4=%b oof=%b last=%b",
                                     out_data.out_fourth, out_data.write_fourth,
                                     out_data.out_of_frame, out_data.last_of_rect);
                        end
                    end
                end
            end

            // predict an accepted pixel, then advance the raster position
            if (in_valid && in_ready)
            begin
                expected_pixels.push_back(predict_pixel(in_data));
                rw = clamp_extent(regs.rect_width, RECT_MAX);
                rh = clamp_extent(regs.rect_height, RECT_MAX);
                if (int'(col_cnt) + 1 >= rw)
                begin
                    col_cnt = '0;
                    row_cnt = (int'(row_cnt) + 1 >= rh) ? '0 : row_cnt + 1'b1;
                end
                else
                begin
                    col_cnt = col_cnt + 1'b1;
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SCREEN_WIDTH: regs.screen_width = cfg_data[SIZE_W-1:0];
                    CFG_RECT_WIDTH:   regs.rect_width   = cfg_data[SIZE_W-1:0];
                    CFG_RECT_HEIGHT:  regs.rect_height  = cfg_data[SIZE_W-1:0];
                    CFG_DEST_X:       regs.dest_x       = cfg_data[POS_W-1:0];
                    CFG_DEST_Y:       regs.dest_y       = cfg_data[POS_W-1:0];
                    CFG_BLEND_MODE:   regs.blend_mode   = cfg_data[1:0];
                    CFG_FILL_COLOR:   regs.fill_color   = cfg_data[23:0];
                    CFG_FILL_ALPHA:   regs.fill_alpha   = cfg_data[CH_W-1:0];
                    default: ;
                endcase
            end

            outstanding = expected_pixels.size();
        end
    end

endmodule

// File: tb/sv/rect_alpha_blend_engine_test.sv
// ============================================================================
// rect_alpha_blend_engine_test - top of the blend engine testbench
// Drives register writes and pixel transactions into the block and takes its
// results with random back-pressure. A directed part covers the corner cases,
// then random phases reconfigure the block while it is idle and send whole
// rectangles, partial ones and stray pixels. The checker beside the block
// predicts and compares; this module only makes stimulus and gives the verdict.
// ============================================================================
module rect_alpha_blend_engine_test;
    import rab_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RANDOM_ITEMS   = 2000;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;

    // Mode code that the package leaves unnamed; the block treats it as copy
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    logic clk;
    logic rst_n;

    rab_stream_if #(.payload_t(pix_in_t))  pix_in_ch ();
    rab_stream_if #(.payload_t(pix_out_t)) pix_out_ch ();
    rab_cfg_if                             cfg_ch ();

    int mismatches;
    int outstanding;
    int in_gap_pct;
    int out_stall_pct;
    int out_stall_left;
    int idle_cycles;

    // Rectangle size as last written, raw register values
    int rect_w_raw;
    int rect_h_raw;

    rect_alpha_blend_engine i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_in_ch),
        .pix_out (pix_out_ch),
        .cfg     (cfg_ch)
    );

    rect_alpha_blend_engine_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_ch.valid),
        .cfg_ready   (cfg_ch.ready),
        .cfg_index   (cfg_ch.index),
        .cfg_data    (cfg_ch.data),
        .in_valid    (pix_in_ch.valid),
        .in_ready    (pix_in_ch.ready),
        .in_data     (pix_in_ch.data),
        .out_valid   (pix_out_ch.valid),
        .out_ready   (pix_out_ch.ready),
        .out_data    (pix_out_ch.data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------------
    // Idle lengths: zero except in the given percentage of calls, which get
    // a short gap, now and then a long one.
    // ------------------------------------------------------------------------
    function automatic int idle_len(input int pct);
        if (int'($urandom_range(99)) >= pct)
            return 0;
        if ($urandom_range(9) == 0)
            return $urandom_range(40, 10);
        return $urandom_range(3, 1);
    endfunction

    // Pacing per phase; zero gives stretches with no idling at all
    function automatic int pick_pct();
        case ($urandom_range(3))
            0:       return 0;
            1:       return 10;
            2:       return 30;
            default: return 60;
        endcase
    endfunction

    // Size register value: mostly from 1 up to the typical size, with the saturating
    // extremes (zero and all ones) and the largest legal size now and then
    function automatic int pick_extent(input int typical);
        case ($urandom_range(15))
            0:       return 0;
            1:       return 4095;
            2:       return 2048;
            3:       return $urandom_range(4095);
            default: return $urandom_range(typical, 1);
        endcase
    endfunction

    function automatic int pick_pos();
        case ($urandom_range(7))
            0:       return 2047;
            1:       return $urandom_range(2047);
            default: return $urandom_range(40);
        endcase
    endfunction

    function automatic pix_in_t random_pixel();
        pix_in_t p;
        p = pix_in_t'({$urandom, $urandom});
        // bias the opacity toward its extremes
        case ($urandom_range(7))
            0:       p.src_alpha = '0;
            1:       p.src_alpha = ALPHA_FULL;
            default: ;
        endcase
        return p;
    endfunction

    function automatic pix_in_t solid_pixel(input logic [CH_W-1:0] src,
                                            input logic [CH_W-1:0] dst,
                                            input logic [CH_W-1:0] alpha);
        pix_in_t p;
        p.src_red    = src;
        p.src_green  = src;
        p.src_blue   = src;
        p.src_fourth = src;
        p.src_alpha  = alpha;
        p.dst_red    = dst;
        p.dst_green  = dst;
        p.dst_blue   = dst;
        return p;
    endfunction

    // ------------------------------------------------------------------------
    // Channel tasks: enter and leave at a falling edge
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input int value);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = CFG_DATA_W'(value);
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
        if (idx == CFG_RECT_WIDTH)
            rect_w_raw = int'(value[SIZE_W-1:0]);
        if (idx == CFG_RECT_HEIGHT)
            rect_h_raw = int'(value[SIZE_W-1:0]);
    endtask

    task automatic send_pixel(input pix_in_t p);
        int gap;
        gap = idle_len(in_gap_pct);
        if (gap > 0)
        begin
            pix_in_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        pix_in_ch.valid = 1'b1;
        pix_in_ch.data  = p;
        do
            @(posedge clk);
        while (!pix_in_ch.ready);
        @(negedge clk);
    endtask

    // Hold the sender until every expected result has come back
    task automatic drain_results();
        pix_in_ch.valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls, changed at the falling edge
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (out_stall_left > 0)
        begin
            pix_out_ch.ready = 1'b0;
            out_stall_left--;
        end
        else
        begin
            pix_out_ch.ready = 1'b1;
            out_stall_left   = idle_len(out_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: count cycles with no transaction on any channel
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (pix_in_ch.valid && pix_in_ch.ready) ||
            (pix_out_ch.valid && pix_out_ch.ready) || (cfg_ch.valid && cfg_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int sent;
        int count;
        int area;
        int ew;
        int eh;

        rst_n            = 1'b0;
        pix_in_ch.valid  = 1'b0;
        pix_in_ch.data   = '0;
        pix_out_ch.ready = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = CFG_SCREEN_WIDTH;
        cfg_ch.data      = '0;
        out_stall_left   = 0;
        idle_cycles      = 0;
        in_gap_pct       = 30;
        out_stall_pct    = 30;
        rect_w_raw       = 1;
        rect_h_raw       = 1;

        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Defaults (1x1 rectangle, per-pixel alpha): opacity and channel
        // extremes, every pixel ends its rectangle
        send_pixel(solid_pixel(8'hff, 8'h00, 8'h00));
        send_pixel(solid_pixel(8'hff, 8'h00, ALPHA_FULL));
        send_pixel(solid_pixel(8'h00, 8'hff, 8'h80));
        send_pixel(solid_pixel(8'h00, 8'hff, ALPHA_FULL));
        send_pixel(random_pixel());

        // Zero stride saturates to one: every column past the first lies
        // outside the frame. Constant colour at zero opacity keeps the frame.
        drain_results();
        write_reg(CFG_SCREEN_WIDTH, 0);
        write_reg(CFG_RECT_WIDTH, 3);
        write_reg(CFG_RECT_HEIGHT, 2);
        write_reg(CFG_DEST_X, 0);
        write_reg(CFG_DEST_Y, 5);
        write_reg(CFG_BLEND_MODE, int'(MODE_FILL));
        write_reg(CFG_FILL_COLOR, 'hff00ff);
        write_reg(CFG_FILL_ALPHA, 0);
        repeat (6) send_pixel(random_pixel());

        // Oversized stride and height saturate, zero width saturates to one.
        // Anchor at the far corner: the first pixel hits the top address, the
        // next rows fall below the frame and their addresses wrap.
        drain_results();
        write_reg(CFG_SCREEN_WIDTH, 4095);
        write_reg(CFG_RECT_WIDTH, 0);
        write_reg(CFG_RECT_HEIGHT, 4095);
        write_reg(CFG_DEST_X, 2047);
        write_reg(CFG_DEST_Y, 2047);
        write_reg(CFG_BLEND_MODE, int'(MODE_COPY));
        send_pixel(solid_pixel(8'hff, 8'h00, 8'h00));
        send_pixel(solid_pixel(8'h00, 8'hff, ALPHA_FULL));
        send_pixel(random_pixel());

        // The unused mode code copies like mode two
        drain_results();
        write_reg(CFG_BLEND_MODE, int'(MODE_UNUSED));
        repeat (2) send_pixel(random_pixel());

        // Shrink the height below the row counter mid-rectangle: the next
        // pixel ends the rectangle
        drain_results();
        write_reg(CFG_RECT_HEIGHT, 2);
        send_pixel(random_pixel());

        // Opaque constant colour, then shrink the width under the column
        // counter: the next pixel ends the row and the rectangle
        drain_results();
        write_reg(CFG_SCREEN_WIDTH, 16);
        write_reg(CFG_DEST_X, 0);
        write_reg(CFG_DEST_Y, 0);
        write_reg(CFG_RECT_WIDTH, 8);
        write_reg(CFG_RECT_HEIGHT, 1);
        write_reg(CFG_BLEND_MODE, int'(MODE_FILL));
        write_reg(CFG_FILL_COLOR, 'h00ff00);
        write_reg(CFG_FILL_ALPHA, int'(ALPHA_FULL));
        repeat (5) send_pixel(random_pixel());
        drain_results();
        write_reg(CFG_RECT_WIDTH, 3);
        send_pixel(random_pixel());

        // Random phases: reconfigure while idle, then mostly whole rectangles
        // with random content; the rest are partial rectangles and stray
        // pixels that leave the counters mid-rectangle.
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            drain_results();
            in_gap_pct    = pick_pct();
            out_stall_pct = pick_pct();

            if ($urandom_range(3) != 0)
                write_reg(CFG_SCREEN_WIDTH, pick_extent(64));
            if ($urandom_range(2) != 0)
                write_reg(CFG_RECT_WIDTH, pick_extent(6));
            if ($urandom_range(2) != 0)
                write_reg(CFG_RECT_HEIGHT, pick_extent(6));
            if ($urandom_range(2) == 0)
                write_reg(CFG_DEST_X, pick_pos());
            if ($urandom_range(2) == 0)
                write_reg(CFG_DEST_Y, pick_pos());
            if ($urandom_range(1) == 0)
                write_reg(CFG_BLEND_MODE, int'($urandom_range(3)));
            if ($urandom_range(2) == 0)
                write_reg(CFG_FILL_COLOR, int'($urandom));
            if ($urandom_range(2) == 0)
            begin
                case ($urandom_range(3))
                    0:       write_reg(CFG_FILL_ALPHA, 0);
                    1:       write_reg(CFG_FILL_ALPHA, int'(ALPHA_FULL));
                    default: write_reg(CFG_FILL_ALPHA, int'($urandom));
                endcase
            end

            // effective rectangle after saturation
            ew   = (rect_w_raw == 0) ? 1 : ((rect_w_raw > RECT_MAX) ? RECT_MAX : rect_w_raw);
            eh   = (rect_h_raw == 0) ? 1 : ((rect_h_raw > RECT_MAX) ? RECT_MAX : rect_h_raw);
            area = ew * eh;
            if ($urandom_range(4) == 0 || area > 300)
                count = $urandom_range(60, 1);
            else
                count = area * int'($urandom_range(3, 1));

            repeat (count)
            begin
                send_pixel(random_pixel());
                sent++;
            end
        end

        // Wait out the last results and let the pipeline settle
        drain_results();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: rect_alpha_blend_engine.f
rtl/rab_pkg.sv
rtl/rab_ifs.sv
rtl/rab_cfg_regs.sv
rtl/rab_raster_cnt.sv
rtl/rab_datapath.sv
rtl/rect_alpha_blend_engine.sv
rtl/rab_checker.sv
tb/sv/rect_alpha_blend_engine_checker.sv
tb/sv/rect_alpha_blend_engine_test.sv
